// File: hw/rtl/mitols_pkg.sv
// ----------------------------------------------------------------------------
// mitols_pkg
// Shared constants, widths and the per-position factor table of the local
// hit score pipeline.
// ----------------------------------------------------------------------------
package mitols_pkg;

    localparam int NUM_POS   = 20;
    localparam int POS_W     = 5;
    localparam int T1_W      = 17;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 20;
    localparam int SCORE_W   = 23;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = NUM_W;

    // survival factors round(65536*(1-m)) per position, q16
    localparam logic [T1_W-1:0] KEEP_Q16 [NUM_POS] = '{
        17'd65536, 17'd65536, 17'd64618, 17'd65536, 17'd65536,
        17'd39649, 17'd44761, 17'd65536, 17'd40042, 17'd60359,
        17'd36372, 17'd32244, 17'd25362, 17'd9765,  17'd17564,
        17'd11272, 17'd25231, 17'd12845, 17'd20644, 17'd27329
    };

endpackage

// File: hw/rtl/mitols_div.sv
// ----------------------------------------------------------------------------
// mitols_div
// Pipelined restoring divider, one quotient bit per stage, with a
// pass-through mismatch count.
// ----------------------------------------------------------------------------
module mitols_div import mitols_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [CNT_W-1:0]   i_cnt,
    output logic               o_valid,
    output logic [SCORE_W-1:0] o_quot,
    output logic [CNT_W-1:0]   o_cnt
);

    logic               r_v   [DIV_STEPS];
    logic [DEN_W:0]     r_rem [DIV_STEPS];
    logic [NUM_W-1:0]   r_num [DIV_STEPS];
    logic [DEN_W-1:0]   r_den [DIV_STEPS];
    logic [CNT_W-1:0]   r_cnt [DIV_STEPS];

    logic               n_v   [DIV_STEPS];
    logic [DEN_W:0]     n_rem [DIV_STEPS];
    logic [NUM_W-1:0]   n_num [DIV_STEPS];
    logic [DEN_W-1:0]   n_den [DIV_STEPS];
    logic [CNT_W-1:0]   n_cnt [DIV_STEPS];

    always_comb begin
        logic [DEN_W:0]   p_rem;
        logic [NUM_W-1:0] p_num;
        logic [DEN_W+1:0] trial;
        for (int s = 0; s < DIV_STEPS; s++) begin
            if (s == 0) begin
                n_v[s]   = i_valid;
                p_rem    = '0;
                p_num    = i_num;
                n_den[s] = i_den;
                n_cnt[s] = i_cnt;
            end else begin
                n_v[s]   = r_v[s-1];
                p_rem    = r_rem[s-1];
                p_num    = r_num[s-1];
                n_den[s] = r_den[s-1];
                n_cnt[s] = r_cnt[s-1];
            end
            trial = {p_rem, p_num[NUM_W-1]};
            if (trial >= {2'b00, n_den[s]}) begin
                n_rem[s] = (DEN_W+1)'(trial - {2'b00, n_den[s]});
                n_num[s] = {p_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[s] = trial[DEN_W:0];
                n_num[s] = {p_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) r_v[s] <= n_v[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
                r_den[s] <= n_den[s];
                r_cnt[s] <= n_cnt[s];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quot  = r_num[DIV_STEPS-1][SCORE_W-1:0];
    assign o_cnt   = r_cnt[DIV_STEPS-1];

endmodule

// File: hw/rtl/mit_offtarget_local_score.sv
// throughput: one mask per cycle; the pipeline advances as a whole and
//   holds while a finished result waits at the output
// stages: the input register (loaded at the transfer edge), 20 factor
//   stages, 2 term stages and a 32-stage divider
// reset: synchronous active-low reset clears all stage valid bits
// ----------------------------------------------------------------------------
// mit_offtarget_local_score
// Local off-target hit score of a folded mismatch mask, q16, with count.
// ----------------------------------------------------------------------------
module mit_offtarget_local_score import mitols_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [19:0]        i_difference_mask,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [SCORE_W-1:0] o_score_q16,
    output logic [CNT_W-1:0]   o_mismatch_count
);

    logic en;

    // factor stages, index 0 is the input register
    logic               r_v     [NUM_POS+1];
    logic [NUM_POS-1:0] r_pos   [NUM_POS+1];
    logic [T1_W-1:0]    r_t1    [NUM_POS+1];
    logic [CNT_W-1:0]   r_n     [NUM_POS+1];
    logic [POS_W-1:0]   r_first [NUM_POS+1];
    logic [POS_W-1:0]   r_last  [NUM_POS+1];

    logic [T1_W-1:0]    n_t1    [NUM_POS];
    logic [CNT_W-1:0]   n_n     [NUM_POS];
    logic [POS_W-1:0]   n_first [NUM_POS];
    logic [POS_W-1:0]   n_last  [NUM_POS];

    logic [NUM_POS-1:0] unfold;

    // term stages
    logic               r_a_v;
    logic [T1_W-1:0]    r_a_t1;
    logic [15:0]        r_a_k;
    logic [10:0]        r_a_d1;
    logic [8:0]         r_a_nn;
    logic [CNT_W-1:0]   r_a_n;
    logic               r_b_v;
    logic [NUM_W-1:0]   r_b_num;
    logic [DEN_W-1:0]   r_b_den;
    logic [CNT_W-1:0]   r_b_n;

    logic [CNT_W-1:0]   nm1;
    logic [POS_W-1:0]   span;
    logic [15:0]        n_k;
    logic [10:0]        n_d1;
    logic [8:0]         n_nn;
    logic [32:0]        prod_num;
    logic [19:0]        prod_den;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        for (int p = 0; p < NUM_POS; p++) begin
            if (p < 10) unfold[p] = i_difference_mask[2*p+1];
            else        unfold[p] = i_difference_mask[2*(p-10)];
        end
    end

    always_comb begin
        logic [2*T1_W-1:0] prod;
        for (int s = 0; s < NUM_POS; s++) begin
            prod       = r_t1[s] * KEEP_Q16[s];
            n_t1[s]    = r_t1[s];
            n_n[s]     = r_n[s];
            n_first[s] = r_first[s];
            n_last[s]  = r_last[s];
            if (r_pos[s][s]) begin
                n_t1[s]   = prod[T1_W+15:16];
                n_n[s]    = CNT_W'(r_n[s] + 1'b1);
                n_last[s] = POS_W'(s);
                if (r_n[s] == '0) n_first[s] = POS_W'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NUM_POS; s++) r_v[s] <= 1'b0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_in_valid;
            for (int s = 0; s < NUM_POS; s++) r_v[s+1] <= r_v[s];
            r_a_v <= r_v[NUM_POS];
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos[0]   <= unfold;
            r_t1[0]    <= T1_W'(65536);
            r_n[0]     <= '0;
            r_first[0] <= '0;
            r_last[0]  <= '0;
            for (int s = 0; s < NUM_POS; s++) begin
                r_pos[s+1]   <= r_pos[s];
                r_t1[s+1]    <= n_t1[s];
                r_n[s+1]     <= n_n[s];
                r_first[s+1] <= n_first[s];
                r_last[s+1]  <= n_last[s];
            end
        end
    end

    // k = 100*a, d1 = a + 4*(a - span) = 95*(n-1) - 4*span
    always_comb begin
        nm1  = CNT_W'(r_n[NUM_POS] - 1'b1);
        span = POS_W'(r_last[NUM_POS] - r_first[NUM_POS]);
        n_nn = 9'(r_n[NUM_POS]) * 9'(r_n[NUM_POS]);
        n_k  = 16'(nm1) * 16'd1900;
        n_d1 = 11'(nm1) * 11'd95 - 11'({span, 2'b00});
        if (r_n[NUM_POS] == '0) begin
            n_k  = '0;
            n_d1 = 11'd1;
            n_nn = 9'd1;
        end else if (r_n[NUM_POS] == CNT_W'(1)) begin
            n_k  = 16'd100;
            n_d1 = 11'd1;
            n_nn = 9'd1;
        end
    end

    assign prod_num = r_a_t1 * r_a_k;
    assign prod_den = r_a_d1 * r_a_nn;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_t1  <= r_t1[NUM_POS];
            r_a_k   <= n_k;
            r_a_d1  <= n_d1;
            r_a_nn  <= n_nn;
            r_a_n   <= r_n[NUM_POS];
            r_b_num <= prod_num[NUM_W-1:0];
            r_b_den <= prod_den;
            r_b_n   <= r_a_n;
        end
    end

    mitols_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_cnt   (r_b_n),
        .o_valid (o_out_valid),
        .o_quot  (o_score_q16),
        .o_cnt   (o_mismatch_count)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives folded mismatch masks into the local hit score pipeline, predicts
// score and mismatch count per mask, and compares each result transfer in
// order, with random idle bursts on both sides except in the back-to-back test.
// ----------------------------------------------------------------------------
module testbench import mitols_pkg::*; ();

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [19:0]        i_difference_mask;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [SCORE_W-1:0] o_score_q16;
    logic [CNT_W-1:0]   o_mismatch_count;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [CNT_W-1:0]   count;
    } t_score;

    t_score score_queue[$];
    int     errors;
    int     masks_sent;
    int     scores_seen;
    bit     idle_on;

    localparam int LATENCY = 54;

    // survival factors per position, q16
    localparam logic [16:0] FACTORS [20] = '{
        17'd65536, 17'd65536, 17'd64618, 17'd65536, 17'd65536,
        17'd39649, 17'd44761, 17'd65536, 17'd40042, 17'd60359,
        17'd36372, 17'd32244, 17'd25362, 17'd9765,  17'd17564,
        17'd11272, 17'd25231, 17'd12845, 17'd20644, 17'd27329
    };

    mit_offtarget_local_score u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_difference_mask(i_difference_mask),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_score_q16      (o_score_q16),
        .o_mismatch_count (o_mismatch_count)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_score local_score(input logic [19:0] mask);
        logic [63:0] t1;
        logic [63:0] a;
        logic [63:0] den;
        int          n;
        int          first;
        int          last;
        int          bit_idx;
        t_score      r;
        t1 = 64'd65536;
        n = 0;
        first = 0;
        last = 0;
        for (int p = 0; p < 20; p++) begin
            bit_idx = (p < 10) ? 2 * p + 1 : 2 * (p - 10);
            if (mask[bit_idx]) begin
                if (n == 0) first = p;
                last = p;
                n++;
                t1 = (t1 * FACTORS[p]) >> 16;
            end
        end
        r.count = n[CNT_W-1:0];
        if (n == 0) begin
            r.score = '0;
        end else if (n == 1) begin
            r.score = SCORE_W'(t1 * 100);
        end else begin
            a = 19 * (n - 1);
            den = (a + 4 * (a - (last - first))) * n * n;
            r.score = SCORE_W'((t1 * 100 * a) / den);
        end
        return r;
    endfunction

    task automatic send_mask(input logic [19:0] mask);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_difference_mask <= mask;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        score_queue.insert(score_queue.size(), local_score(mask));
        masks_sent++;
    endtask

    // sink side: random stall bursts
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                stall = $urandom_range(1, 15);
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_score want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            scores_seen++;
            if (score_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer: score %0d count %0d",
                                           o_score_q16, o_mismatch_count);
            end else begin
                want = score_queue.pop_front();
                if (want.score !== o_score_q16 || want.count !== o_mismatch_count) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected score %0d count %0d, got %0d %0d",
                                 want.score, want.count, o_score_q16, o_mismatch_count);
                end
            end
        end
    end

    task automatic test_directed();
        logic [19:0] m;
        send_mask(20'h00000);
        send_mask(20'hFFFFF);
        for (int b = 0; b < 20; b++) send_mask(20'h1 << b);
        send_mask(20'hAAAAA);
        send_mask(20'h55555);
        m = 20'h00002 | 20'h00001;  // positions 0 and 10
        send_mask(m);
        send_mask(20'h40002);       // positions 0 and 19, widest span
    endtask

    task automatic test_random(input int count);
        logic [19:0] m;
        int          k;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: m = 20'($urandom);
                1: begin
                    m = '0;
                    k = $urandom_range(1, 4);
                    repeat (k) m[$urandom_range(0, 19)] = 1'b1;
                end
                2: m = ~(20'h1 << $urandom_range(0, 19)) & 20'($urandom);
                default: m = 20'($urandom & $urandom);
            endcase
            send_mask(m);
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        test_random(count);
    endtask

    initial begin
        int waited;
        errors = 0;
        masks_sent = 0;
        scores_seen = 0;
        idle_on = 1'b1;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_difference_mask <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1500);
        test_back_to_back(380);
        i_in_valid <= 1'b0;
        waited = 0;
        while (score_queue.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d masks, checked %0d results, %0d left over",
                 masks_sent, scores_seen, score_queue.size());
        if (errors == 0 && score_queue.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// File: mit_offtarget_local_score.f
hw/rtl/mitols_pkg.sv
hw/rtl/mitols_div.sv
hw/rtl/mit_offtarget_local_score.sv
tb/sv/testbench.sv
